// ===== rtl/core/rgbcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbcf_pkg
// Shared types and constants of the RGB 3x3 convolution filter.
// ----------------------------------------------------------------------------
package rgbcf_pkg;

    // Line store depth, which is also the widest image row.
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_W      = 12;
    localparam int PIX_W      = 24;
    localparam int MIN_SIZE   = 3;

    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;
    localparam int NUM_TAPS     = 9;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic MODE_GAUSS   = 1'b0;
    localparam logic MODE_LAPLACE = 1'b1;

    localparam logic [CFG_WIDTH_W-1:0]  RESET_WIDTH  = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_last;
    } t_result;

    // Last column and last row positions of the clamped frame size.
    typedef struct packed {
        logic [COL_W-1:0] w_last;
        logic [ROW_W-1:0] h_last;
    } t_geom;

    // Status of the item sitting in the window stage.
    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
    } t_stage;

    // Column-major taps: left column top to bottom, then middle, then right.
    typedef logic [NUM_TAPS-1:0][PIX_W-1:0] t_taps;
    typedef logic [NUM_TAPS-1:0][7:0]       t_chan_taps;

endpackage

// ===== rtl/core/rgbcf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbcf_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rgbcf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rgbcf_kernel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbcf_kernel
// One color channel of the 3x3 Gaussian or Laplacian convolution.
// ----------------------------------------------------------------------------
module rgbcf_kernel
    import rgbcf_pkg::*;
(
    input  logic       i_mode,
    input  t_chan_taps i_taps,
    output logic [7:0] o_value
);

    logic [11:0]        gauss_sum;
    logic [11:0]        ring_sum;
    logic [12:0]        center9;
    logic signed [12:0] lap_sum;
    logic [11:0]        lap_mag;
    logic [7:0]         lap_sat;

    // Gaussian weights 1-2-1 / 2-4-2 / 1-2-1; the sum never exceeds 4080.
    assign gauss_sum = 12'(i_taps[0]) + 12'({i_taps[1], 1'b0}) + 12'(i_taps[2])
                     + 12'({i_taps[3], 1'b0}) + 12'({i_taps[4], 2'b00})
                     + 12'({i_taps[5], 1'b0}) + 12'(i_taps[6])
                     + 12'({i_taps[7], 1'b0}) + 12'(i_taps[8]);

    // Laplacian sharpen: nine times the center minus the eight neighbors.
    assign ring_sum = 12'(i_taps[0]) + 12'(i_taps[1]) + 12'(i_taps[2])
                    + 12'(i_taps[3]) + 12'(i_taps[5]) + 12'(i_taps[6])
                    + 12'(i_taps[7]) + 12'(i_taps[8]);
    assign center9  = 13'({i_taps[4], 3'b000}) + 13'(i_taps[4]);
    assign lap_sum  = $signed(center9) - $signed({1'b0, ring_sum});
    assign lap_mag  = lap_sum[12] ? 12'(-lap_sum) : lap_sum[11:0];
    assign lap_sat  = (lap_mag > 12'd255) ? 8'hFF : lap_mag[7:0];

    assign o_value = (i_mode == MODE_LAPLACE) ? lap_sat : gauss_sum[11:4];

endmodule

// ===== rtl/core/rgbcf_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbcf_window
// Raster counters, the two line stores and the 3x3 window registers.
// ----------------------------------------------------------------------------
module rgbcf_window
    import rgbcf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_accept,
    input  t_pixel i_pixel,
    input  t_geom  i_geom,
    input  logic   i_advance,
    output t_stage o_stage,
    output t_taps  o_taps
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_s1_valid, n_s1_valid;
    logic             r_s1_emit;
    logic             r_s1_last;
    logic [COL_W-1:0] r_s1_col;
    logic [PIX_W-1:0] r_s1_px;
    logic [PIX_W-1:0] r_win [6];
    logic [PIX_W-1:0] top_px;
    logic [PIX_W-1:0] mid_px;
    logic             last_col;
    logic             last_row;

    assign last_col = (r_col >= i_geom.w_last);
    assign last_row = (r_row >= i_geom.h_last);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (i_accept) begin
            n_s1_valid = 1'b1;
        end else if (i_advance) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_emit <= (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
            r_s1_last <= last_col && last_row;
            r_s1_col  <= r_col;
            r_s1_px   <= i_pixel;
        end
    end

    // The window shifts one column left each time an item leaves the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_advance) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top_px;
            r_win[4] <= mid_px;
            r_win[5] <= r_s1_px;
        end
    end

    rgbcf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .i_clk   (i_clk),
        .i_we    (i_advance),
        .i_waddr (r_s1_col),
        .i_wdata (mid_px),
        .i_re    (i_accept),
        .i_raddr (r_col),
        .o_rdata (top_px)
    );

    rgbcf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lower (
        .i_clk   (i_clk),
        .i_we    (i_advance),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_px),
        .i_re    (i_accept),
        .i_raddr (r_col),
        .o_rdata (mid_px)
    );

    assign o_stage.valid = r_s1_valid;
    assign o_stage.emit  = r_s1_emit;
    assign o_stage.last  = r_s1_last;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            o_taps[k] = r_win[k];
        end
        o_taps[6] = top_px;
        o_taps[7] = mid_px;
        o_taps[8] = r_s1_px;
    end

    a_advance_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance |-> r_s1_valid)
        else $error("window stage advanced without an item");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_s1_valid)
        else $error("accepted request did not reach the window stage");

    a_stall_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !i_advance) |=> (r_s1_valid && $stable(r_s1_px)
                                        && $stable(top_px) && $stable(mid_px)))
        else $error("stalled window stage lost its taps");

    a_last_is_emitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |-> r_s1_emit)
        else $error("frame end flagged on a border pixel");

endmodule

// ===== rtl/core/rgb_3x3_convolution_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_3x3_convolution_filter_unit
// 3x3 Gaussian / Laplacian filter over a raster stream of RGB pixels.
// ----------------------------------------------------------------------------
// A result is formed in the window stage after the request of the pixel below
// and to the right of its window center is accepted, and is then registered in
// the output register when it is free. Throughput: one pixel request per cycle
// unless the output stalls; the line store is read in the cycle before the stage.
// Reset (synchronous, active low) clears the counters, window and pipeline;
// line store contents are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module rgb_3x3_convolution_filter_unit
    import rgbcf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Pixel request channel.
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_pixel                i_in_data,

    // Filtered result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_result               o_out_data,

    // APB-style register port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------------
    logic                    r_mode;
    logic [CFG_WIDTH_W-1:0]  r_width;
    logic [CFG_HEIGHT_W-1:0] r_height;
    logic                    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_GAUSS;
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_MODE:   r_mode   <= pwdata[0];
                REG_WIDTH:  r_width  <= pwdata[CFG_WIDTH_W-1:0];
                REG_HEIGHT: r_height <= pwdata[CFG_HEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE:   prdata = APB_DATA_W'(r_mode);
            REG_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Frame geometry. Sizes outside the supported range are clamped: the
    // width to 3..MAX_WIDTH and the height to 3..MAX_HEIGHT. The counters
    // compare against the last position rather than the size itself.
    // ------------------------------------------------------------------------
    logic [31:0] width_clamp;
    logic [31:0] height_clamp;
    t_geom       geom;

    always_comb begin
        width_clamp = 32'(r_width);
        if (width_clamp < 32'(MIN_SIZE)) begin
            width_clamp = 32'(MIN_SIZE);
        end else if (width_clamp > 32'(MAX_WIDTH)) begin
            width_clamp = 32'(MAX_WIDTH);
        end
        height_clamp = 32'(r_height);
        if (height_clamp < 32'(MIN_SIZE)) begin
            height_clamp = 32'(MIN_SIZE);
        end else if (height_clamp > 32'(MAX_HEIGHT)) begin
            height_clamp = 32'(MAX_HEIGHT);
        end
        geom.w_last = COL_W'(width_clamp - 32'd1);
        geom.h_last = ROW_W'(height_clamp - 32'd1);
    end

    // ------------------------------------------------------------------------
    // Flow control. The window stage holds one pixel whose line store reads
    // are complete. It moves on whenever it has no result to deliver or the
    // output register is free or draining, so requests keep coming in at one
    // per cycle as long as the output register empties in the same cycle.
    // ------------------------------------------------------------------------
    t_stage stage;
    t_taps  taps;
    logic   advance;
    logic   in_accept;

    assign advance    = stage.valid && (!stage.emit || !o_out_valid || i_out_ready);
    assign o_in_ready = !stage.valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    rgbcf_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_pixel   (i_in_data),
        .i_geom    (geom),
        .i_advance (advance),
        .o_stage   (stage),
        .o_taps    (taps)
    );

    // ------------------------------------------------------------------------
    // Per-channel convolution on the window taps.
    // ------------------------------------------------------------------------
    t_chan_taps red_taps;
    t_chan_taps green_taps;
    t_chan_taps blue_taps;
    logic [7:0] red_val;
    logic [7:0] green_val;
    logic [7:0] blue_val;

    always_comb begin
        for (int k = 0; k < NUM_TAPS; k++) begin
            red_taps[k]   = taps[k][23:16];
            green_taps[k] = taps[k][15:8];
            blue_taps[k]  = taps[k][7:0];
        end
    end

    rgbcf_kernel u_kernel_red (
        .i_mode  (r_mode),
        .i_taps  (red_taps),
        .o_value (red_val)
    );

    rgbcf_kernel u_kernel_green (
        .i_mode  (r_mode),
        .i_taps  (green_taps),
        .o_value (green_val)
    );

    rgbcf_kernel u_kernel_blue (
        .i_mode  (r_mode),
        .i_taps  (blue_taps),
        .o_value (blue_val)
    );

    // ------------------------------------------------------------------------
    // Output register. Border pixels leave the window stage without a result.
    // ------------------------------------------------------------------------
    logic    r_out_valid, n_out_valid;
    t_result r_out;
    logic    load_out;

    assign load_out = advance && stage.emit;

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.out_red    <= red_val;
            r_out.out_green  <= green_val;
            r_out.out_blue   <= blue_val;
            r_out.frame_last <= stage.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
